// ----- sv/stm_pkg.sv -----
package stm_pkg;

  localparam int VEL_W   = 24;
  localparam int WGT_W   = 24;
  localparam int SQ_W    = 49;
  localparam int SUM_W   = 64;
  localparam int WSUM_W  = 48;
  localparam int MS_W    = 32;
  localparam int TEMP_W  = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int MUL_W   = 33;
  localparam int PROD_W  = 66;

  localparam logic [CFG_IDX_W-1:0] CFG_DRIFT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MS0   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MS1   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MS2   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MS3   = 3'd4;

  localparam logic FUNC_ACC    = 1'b0;
  localparam logic FUNC_REPORT = 1'b1;

  // Accumulate runs eight multiplies; the last product retires on step ACC_STEPS.
  localparam logic [3:0] ACC_STEPS = 4'd8;
  localparam logic [23:0] DRIFT_CLAMP = 24'h800000;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ACC,
    S_RCHK,
    S_DIVM,
    S_DIVD,
    S_SQ,
    S_SQA,
    S_DIFF,
    S_MLO,
    S_MHI,
    S_FIN
  } stm_state_t;

  function automatic logic [SUM_W-1:0] sat_add_s64(input logic [SUM_W-1:0] a,
                                                   input logic [47:0] b);
    logic [SUM_W:0] s;
    s = {a[SUM_W-1], a} + {{17{b[47]}}, b};
    if (s[SUM_W] != s[SUM_W-1]) begin
      sat_add_s64 = s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      sat_add_s64 = s[SUM_W-1:0];
    end
  endfunction

  function automatic logic [SUM_W-1:0] magnitude64(input logic [SUM_W-1:0] d);
    magnitude64 = d[SUM_W-1] ? (~d + 64'd1) : d;
  endfunction

endpackage

// ----- sv/stm_in_if.sv -----
interface stm_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [1:0]  type_index;
  logic signed [stm_pkg::VEL_W-1:0] vel_x;
  logic signed [stm_pkg::VEL_W-1:0] vel_y;
  logic signed [stm_pkg::VEL_W-1:0] vel_z;
  logic [stm_pkg::WGT_W-1:0] weight;

  modport source (output valid, func, type_index, vel_x, vel_y, vel_z, weight, input ready);
  modport sink   (input valid, func, type_index, vel_x, vel_y, vel_z, weight, output ready);
endinterface

// ----- sv/stm_out_if.sv -----
interface stm_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  out_type;
  logic        occupied;
  logic [stm_pkg::TEMP_W-1:0] temperature;
  logic        last;

  modport source (output valid, out_type, occupied, temperature, last, input ready);
  modport sink   (input valid, out_type, occupied, temperature, last, output ready);
endinterface

// ----- sv/stm_div.sv -----
module stm_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [stm_pkg::SUM_W-1:0]   num,
  input  logic [stm_pkg::WSUM_W-1:0]  den,
  output logic                        done,
  output logic [stm_pkg::SUM_W-1:0]   quo
);

  logic [stm_pkg::SUM_W-1:0]  q_r, q_nxt;
  logic [stm_pkg::WSUM_W-1:0] rem_r, rem_nxt;
  logic [stm_pkg::WSUM_W-1:0] den_r;
  logic [6:0]                 cnt_r, cnt_nxt;
  logic                       done_r, done_nxt;
  logic [stm_pkg::WSUM_W:0]   rem_sh;
  logic [stm_pkg::WSUM_W:0]   rem_sub;

  // Restoring division, one quotient bit per cycle.
  always_comb begin
    rem_sh   = {rem_r, q_r[stm_pkg::SUM_W-1]};
    rem_sub  = rem_sh - {1'b0, den_r};
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      q_nxt   = num;
      rem_nxt = '0;
      cnt_nxt = 7'd64;
    end else if (cnt_r != 7'd0) begin
      if (!rem_sub[stm_pkg::WSUM_W]) begin
        rem_nxt = rem_sub[stm_pkg::WSUM_W-1:0];
        q_nxt   = {q_r[stm_pkg::SUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[stm_pkg::WSUM_W-1:0];
        q_nxt   = {q_r[stm_pkg::SUM_W-2:0], 1'b0};
      end
      cnt_nxt  = cnt_r - 7'd1;
      done_nxt = (cnt_r == 7'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      den_r <= den;
    end
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule

// ----- sv/species_temperature_moments.sv -----
// Channel   Direction  Carries
// in_ch     sink       func, type_index, vel_x/y/z, weight
// out_ch    source     out_type, occupied, temperature, last
// cfg_*     write      account_for_drift, mass_scale_0..3
//
// An accumulate makes eight passes through the shared 33x33 multiplier.
// A report walks the species; each occupied one needs one divide for the mean square
// (three more with drift on, each followed by a squaring step), then the MLO and MHI multiply steps.
// in_ch.ready is high only while the sequencer is idle; a waiting result in the
// output register stalls the next species but not the next accept.
// Synchronous reset clears all stores and restores account_for_drift to 1.
module species_temperature_moments #(
  parameter int NUM_SPECIES = 4
) (
  input  logic                            clk,
  input  logic                            rst_n,
  stm_in_if.sink                          in_ch,
  stm_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [stm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [stm_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int IDW = (NUM_SPECIES > 1) ? $clog2(NUM_SPECIES) : 1;
  localparam logic [IDW-1:0] LAST_ID = IDW'(NUM_SPECIES - 1);

  stm_pkg::stm_state_t state_r, state_nxt;

  logic [stm_pkg::SUM_W-1:0]  sss_r [NUM_SPECIES];
  logic [stm_pkg::SUM_W-1:0]  dsx_r [NUM_SPECIES];
  logic [stm_pkg::SUM_W-1:0]  dsy_r [NUM_SPECIES];
  logic [stm_pkg::SUM_W-1:0]  dsz_r [NUM_SPECIES];
  logic [stm_pkg::WSUM_W-1:0] wsum_r [NUM_SPECIES];

  logic                   drift_en_r;
  logic [stm_pkg::MS_W-1:0] ms_r [4];

  logic [3:0]             step_r, step_nxt;
  logic [IDW-1:0]         id_r, id_nxt;
  logic [IDW-1:0]         acc_id_r;
  logic signed [stm_pkg::VEL_W-1:0] vx_r, vy_r, vz_r;
  logic [stm_pkg::WGT_W-1:0] w_r;
  logic [stm_pkg::SQ_W-1:0]  sq_r;
  logic [stm_pkg::SUM_W-1:0] plo_r;
  logic [stm_pkg::SUM_W-1:0] m_r;
  logic [stm_pkg::SQ_W-1:0]  d2_r;
  logic [stm_pkg::SUM_W-1:0] diff_r;
  logic [23:0]            dq_r;
  logic [1:0]             axis_r, axis_nxt;
  logic signed [stm_pkg::PROD_W-1:0] p_r, p_nxt;
  logic signed [stm_pkg::MUL_W-1:0]  ma, mb;

  logic                   out_valid_r;
  logic [1:0]             out_type_r;
  logic                   out_occ_r;
  logic [stm_pkg::TEMP_W-1:0] out_temp_r;
  logic                   out_last_r;

  logic                   accept, out_free, push, push_occ, clear_id;
  logic [stm_pkg::TEMP_W-1:0] push_temp;

  logic                   div_start, div_done;
  logic [stm_pkg::SUM_W-1:0] div_num, div_quo;
  logic [1:0]             mag_axis;
  logic [stm_pkg::SUM_W-1:0] drift_mag;

  logic [2:0]             id3;
  logic [stm_pkg::MS_W-1:0] ms_sel;
  logic [73:0]            prod74;
  logic [stm_pkg::SUM_W-1:0] acc_prod;
  logic [40:0]            rsum;

  assign accept   = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == stm_pkg::S_IDLE);
  assign out_free = !out_valid_r || out_ch.ready;
  assign id3      = 3'(id_r);
  assign ms_sel   = (id3 < 3'd4) ? ms_r[id3[1:0]] : '0;

  stm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (wsum_r[id_r]),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_comb begin
    case (mag_axis)
      2'd0:    drift_mag = stm_pkg::magnitude64(dsx_r[id_r]);
      2'd1:    drift_mag = stm_pkg::magnitude64(dsy_r[id_r]);
      default: drift_mag = stm_pkg::magnitude64(dsz_r[id_r]);
    endcase
  end

  // Shared multiplier operand select.
  always_comb begin
    ma = '0;
    mb = '0;
    if (state_r == stm_pkg::S_ACC) begin
      case (step_r)
        4'd0: begin ma = {{9{vx_r[23]}}, vx_r}; mb = {{9{vx_r[23]}}, vx_r}; end
        4'd1: begin ma = {{9{vy_r[23]}}, vy_r}; mb = {{9{vy_r[23]}}, vy_r}; end
        4'd2: begin ma = {{9{vz_r[23]}}, vz_r}; mb = {{9{vz_r[23]}}, vz_r}; end
        4'd3: begin ma = {{9{vx_r[23]}}, vx_r}; mb = {9'd0, w_r}; end
        4'd4: begin ma = {{9{vy_r[23]}}, vy_r}; mb = {9'd0, w_r}; end
        4'd5: begin ma = {{9{vz_r[23]}}, vz_r}; mb = {9'd0, w_r}; end
        4'd6: begin ma = {1'b0, sq_r[31:0]}; mb = {9'd0, w_r}; end
        4'd7: begin ma = {16'd0, sq_r[48:32]}; mb = {9'd0, w_r}; end
        default: ;
      endcase
    end else if (state_r == stm_pkg::S_SQ) begin
      ma = {9'd0, dq_r};
      mb = {9'd0, dq_r};
    end else if (state_r == stm_pkg::S_MLO) begin
      ma = {1'b0, ms_sel};
      mb = {1'b0, diff_r[31:0]};
    end else if (state_r == stm_pkg::S_MHI || state_r == stm_pkg::S_FIN) begin
      // The high partial product is kept alive while the result waits for space.
      ma = {1'b0, ms_sel};
      mb = {1'b0, diff_r[63:32]};
    end
  end

  assign p_nxt = ma * mb;

  // Particle product w*|v|^2 from its two partial products, saturated to 64 bits.
  assign prod74   = {1'b0, p_r[40:0], 32'd0} + {18'd0, plo_r[55:0]};
  assign acc_prod = (prod74[73:64] != 10'd0) ? '1 : prod74[63:0];
  assign rsum     = {9'd0, p_r[23:0], 8'd0} + {1'b0, plo_r[63:24]};

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    id_nxt    = id_r;
    axis_nxt  = axis_r;
    div_start = 1'b0;
    div_num   = sss_r[id_r];
    mag_axis  = axis_r;
    push      = 1'b0;
    push_occ  = 1'b0;
    push_temp = '0;
    clear_id  = 1'b0;
    case (state_r)
      stm_pkg::S_IDLE: begin
        if (accept) begin
          if (in_ch.func == stm_pkg::FUNC_REPORT) begin
            id_nxt    = '0;
            state_nxt = stm_pkg::S_RCHK;
          end else if (32'(in_ch.type_index) < NUM_SPECIES) begin
            step_nxt  = '0;
            state_nxt = stm_pkg::S_ACC;
          end
        end
      end
      stm_pkg::S_ACC: begin
        step_nxt = step_r + 4'd1;
        if (step_r == stm_pkg::ACC_STEPS) begin
          state_nxt = stm_pkg::S_IDLE;
        end
      end
      stm_pkg::S_RCHK: begin
        if (wsum_r[id_r] == '0) begin
          if (out_free) begin
            push     = 1'b1;
            clear_id = 1'b1;
            if (id_r == LAST_ID) begin
              state_nxt = stm_pkg::S_IDLE;
            end else begin
              id_nxt = id_r + 1'b1;
            end
          end
        end else begin
          div_start = 1'b1;
          state_nxt = stm_pkg::S_DIVM;
        end
      end
      stm_pkg::S_DIVM: begin
        if (div_done) begin
          if (drift_en_r) begin
            axis_nxt  = 2'd0;
            mag_axis  = 2'd0;
            div_num   = drift_mag;
            div_start = 1'b1;
            state_nxt = stm_pkg::S_DIVD;
          end else begin
            state_nxt = stm_pkg::S_DIFF;
          end
        end
      end
      stm_pkg::S_DIVD: begin
        if (div_done) begin
          state_nxt = stm_pkg::S_SQ;
        end
      end
      stm_pkg::S_SQ: state_nxt = stm_pkg::S_SQA;
      stm_pkg::S_SQA: begin
        if (axis_r == 2'd2) begin
          state_nxt = stm_pkg::S_DIFF;
        end else begin
          axis_nxt  = axis_r + 2'd1;
          mag_axis  = axis_r + 2'd1;
          div_num   = drift_mag;
          div_start = 1'b1;
          state_nxt = stm_pkg::S_DIVD;
        end
      end
      stm_pkg::S_DIFF: state_nxt = stm_pkg::S_MLO;
      stm_pkg::S_MLO:  state_nxt = stm_pkg::S_MHI;
      stm_pkg::S_MHI:  state_nxt = stm_pkg::S_FIN;
      stm_pkg::S_FIN: begin
        push_occ = 1'b1;
        if (p_r[63:24] != '0 || rsum[40:32] != '0) begin
          push_temp = '1;
        end else begin
          push_temp = rsum[31:0];
        end
        if (out_free) begin
          push     = 1'b1;
          clear_id = 1'b1;
          if (id_r == LAST_ID) begin
            state_nxt = stm_pkg::S_IDLE;
          end else begin
            id_nxt    = id_r + 1'b1;
            state_nxt = stm_pkg::S_RCHK;
          end
        end
      end
      default: state_nxt = stm_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= stm_pkg::S_IDLE;
      step_r  <= '0;
      id_r    <= '0;
      axis_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      id_r    <= id_nxt;
      axis_r  <= axis_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    p_r <= p_nxt;
    if (accept) begin
      vx_r     <= in_ch.vel_x;
      vy_r     <= in_ch.vel_y;
      vz_r     <= in_ch.vel_z;
      w_r      <= in_ch.weight;
      acc_id_r <= IDW'(in_ch.type_index);
    end
    if (state_r == stm_pkg::S_ACC) begin
      case (step_r)
        4'd1: sq_r <= p_r[48:0];
        4'd2, 4'd3: sq_r <= sq_r + p_r[48:0];
        4'd7: plo_r <= p_r[63:0];
        default: ;
      endcase
    end
    if (state_r == stm_pkg::S_DIVM && div_done) begin
      m_r  <= div_quo;
      d2_r <= '0;
    end
    if (state_r == stm_pkg::S_DIVD && div_done) begin
      dq_r <= (div_quo > 64'(stm_pkg::DRIFT_CLAMP)) ? stm_pkg::DRIFT_CLAMP : div_quo[23:0];
    end
    if (state_r == stm_pkg::S_SQA) begin
      d2_r <= d2_r + p_r[48:0];
    end
    if (state_r == stm_pkg::S_DIFF) begin
      diff_r <= (m_r > 64'(d2_r)) ? (m_r - 64'(d2_r)) : '0;
    end
    if (state_r == stm_pkg::S_MHI) begin
      plo_r <= p_r[63:0];
    end
  end

  // Per-species stores.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SPECIES; i++) begin
        sss_r[i]  <= '0;
        dsx_r[i]  <= '0;
        dsy_r[i]  <= '0;
        dsz_r[i]  <= '0;
        wsum_r[i] <= '0;
      end
    end else if (clear_id) begin
      sss_r[id_r]  <= '0;
      dsx_r[id_r]  <= '0;
      dsy_r[id_r]  <= '0;
      dsz_r[id_r]  <= '0;
      wsum_r[id_r] <= '0;
    end else if (state_r == stm_pkg::S_ACC) begin
      case (step_r)
        4'd4: dsx_r[acc_id_r] <= stm_pkg::sat_add_s64(dsx_r[acc_id_r], p_r[47:0]);
        4'd5: dsy_r[acc_id_r] <= stm_pkg::sat_add_s64(dsy_r[acc_id_r], p_r[47:0]);
        4'd6: dsz_r[acc_id_r] <= stm_pkg::sat_add_s64(dsz_r[acc_id_r], p_r[47:0]);
        4'd8: begin
          sss_r[acc_id_r] <= ({1'b0, sss_r[acc_id_r]} + {1'b0, acc_prod} > 65'h0_FFFF_FFFF_FFFF_FFFF)
                             ? '1 : sss_r[acc_id_r] + acc_prod;
          wsum_r[acc_id_r] <= ({1'b0, wsum_r[acc_id_r]} + 49'(w_r) > 49'h0_FFFF_FFFF_FFFF)
                              ? '1 : wsum_r[acc_id_r] + 48'(w_r);
        end
        default: ;
      endcase
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drift_en_r <= 1'b1;
      for (int i = 0; i < 4; i++) begin
        ms_r[i] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        stm_pkg::CFG_DRIFT: drift_en_r <= cfg_data[0];
        stm_pkg::CFG_MS0:   ms_r[0] <= cfg_data;
        stm_pkg::CFG_MS1:   ms_r[1] <= cfg_data;
        stm_pkg::CFG_MS2:   ms_r[2] <= cfg_data;
        stm_pkg::CFG_MS3:   ms_r[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
    if (push) begin
      out_type_r <= id3[1:0];
      out_occ_r  <= push_occ;
      out_temp_r <= push_temp;
      out_last_r <= (id_r == LAST_ID);
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_type    = out_type_r;
  assign out_ch.occupied    = out_occ_r;
  assign out_ch.temperature = out_temp_r;
  assign out_ch.last        = out_last_r;

  a_div_only_in_report: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == stm_pkg::S_DIVM || state_r == stm_pkg::S_DIVD))
    else $error("divider finished outside a report step");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!out_valid_r || out_ch.ready))
    else $error("result pushed over a pending transaction");

  a_last_ends_report: assert property (@(posedge clk) disable iff (!rst_n)
    (push && id_r == LAST_ID) |=> (state_r == stm_pkg::S_IDLE))
    else $error("report did not end after the last species");

  a_acc_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == stm_pkg::S_ACC && step_r == stm_pkg::ACC_STEPS) |=> in_ch.ready)
    else $error("accumulate did not return to idle");

endmodule

// ----- tb/stm_tb_if.sv -----
`timescale 1ns / 1ps
// The block's channel interfaces come with the RTL; nothing extra is needed here.
// This file carries a small record type shared by the testbench top.
package stm_tb_types;
  typedef struct packed {
    logic [1:0]  out_type;
    logic        occupied;
    logic [31:0] temperature;
    logic        last;
  } species_report_t;
endpackage

// ----- tb/species_temperature_moments_tb.sv -----
`timescale 1ns / 1ps
module species_temperature_moments_tb;

  localparam int NSP = 4;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [stm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [stm_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  stm_in_if in_ch ();
  stm_out_if out_ch ();

  species_temperature_moments #(.NUM_SPECIES(NSP)) u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // Shadow copy of the block's configuration and per-species moment stores.
  logic        drift_on;
  logic [31:0] mass_scale [4];
  logic [63:0] sq_acc [NSP];
  logic signed [63:0] vx_acc [NSP], vy_acc [NSP], vz_acc [NSP];
  logic [47:0] w_acc [NSP];

  stm_tb_types::species_report_t pending_reports[$];
  int errors = 0;
  bit stim_done = 1'b0;

  typedef struct {
    logic func;
    logic [1:0] sp;
    logic signed [23:0] vx, vy, vz;
    logic [23:0] w;
    bit has_fixed;
    logic [31:0] fixed_temp;
  } particle_row_t;

  function automatic logic signed [63:0] sat_sum(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
    if (s < -65'sh0_8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] drift_mean(input logic signed [63:0] d,
                                                     input logic [47:0] w);
    logic [63:0] mag, q;
    mag = d[63] ? (~d + 64'd1) : d;
    q = mag / w;
    if (q > 64'd8388608) q = 64'd8388608;
    return d[63] ? -$signed(q) : $signed(q);
  endfunction

  function automatic logic [31:0] species_temp(input int id);
    logic [63:0] m, d2, diff, plo, phi, r;
    logic signed [63:0] dx, dy, dz;
    m = sq_acc[id] / w_acc[id];
    d2 = 0;
    if (drift_on) begin
      dx = drift_mean(vx_acc[id], w_acc[id]);
      dy = drift_mean(vy_acc[id], w_acc[id]);
      dz = drift_mean(vz_acc[id], w_acc[id]);
      d2 = dx * dx + dy * dy + dz * dz;
    end
    diff = (m > d2) ? m - d2 : 64'd0;
    plo = mass_scale[id] * diff[31:0];
    phi = mass_scale[id] * diff[63:32];
    if (phi >= 64'd16777216) return 32'hFFFF_FFFF;
    r = (phi << 8) + (plo >> 24);
    return (r > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : r[31:0];
  endfunction

  task automatic predict_particle(input particle_row_t p);
    stm_tb_types::species_report_t rep;
    logic signed [63:0] vx, vy, vz, w;
    logic [63:0] sq, prod;
    logic [48:0] ws;
    if (p.func == stm_pkg::FUNC_ACC) begin
      vx = p.vx; vy = p.vy; vz = p.vz; w = {40'd0, p.w};
      sq = vx * vx + vy * vy + vz * vz;
      prod = (p.w != 0 && sq > 64'hFFFF_FFFF_FFFF_FFFF / w) ? 64'hFFFF_FFFF_FFFF_FFFF
                                                             : sq * w;
      sq_acc[p.sp] = (sq_acc[p.sp] > ~prod) ? 64'hFFFF_FFFF_FFFF_FFFF
                                            : sq_acc[p.sp] + prod;
      vx_acc[p.sp] = sat_sum(vx_acc[p.sp], vx * w);
      vy_acc[p.sp] = sat_sum(vy_acc[p.sp], vy * w);
      vz_acc[p.sp] = sat_sum(vz_acc[p.sp], vz * w);
      ws = w_acc[p.sp] + p.w;
      w_acc[p.sp] = ws[48] ? 48'hFFFF_FFFF_FFFF : ws[47:0];
    end else begin
      for (int i = 0; i < NSP; i++) begin
        rep.out_type = i[1:0];
        rep.occupied = (w_acc[i] != 0);
        rep.temperature = rep.occupied ? species_temp(i) : 32'd0;
        rep.last = (i == NSP - 1);
        if (p.has_fixed) rep.temperature = p.fixed_temp;
        pending_reports.push_back(rep);
      end
      for (int i = 0; i < NSP; i++) begin
        sq_acc[i] = 0; vx_acc[i] = 0; vy_acc[i] = 0; vz_acc[i] = 0; w_acc[i] = 0;
      end
    end
  endtask

  task automatic write_reg(input logic [stm_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == stm_pkg::CFG_DRIFT) drift_on = val[0];
    else mass_scale[2'(idx - stm_pkg::CFG_MS0)] = val;
  endtask

  // Valid stays high between back-to-back transactions; it drops only for a gap.
  task automatic send_particle(input particle_row_t p);
    int gap;
    gap = $urandom_range(0, 17);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.func <= p.func;
    in_ch.type_index <= p.sp;
    in_ch.vel_x <= p.vx;
    in_ch.vel_y <= p.vy;
    in_ch.vel_z <= p.vz;
    in_ch.weight <= p.w;
    do @(posedge clk); while (!in_ch.ready);
    predict_particle(p);
  endtask

  task automatic drain_reports();
    in_ch.valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    // An accumulate may still be in flight after the last report arrived.
    repeat (20) @(posedge clk);
  endtask

  function automatic particle_row_t rand_particle(input int report_pct);
    particle_row_t p;
    p.func = ($urandom_range(0, 99) < report_pct) ? stm_pkg::FUNC_REPORT : stm_pkg::FUNC_ACC;
    p.sp = 2'($urandom_range(0, 3));
    case ($urandom_range(0, 3))
      0: begin
        p.vx = 24'($urandom); p.vy = 24'($urandom); p.vz = 24'($urandom);
      end
      default: begin
        // Mostly a common drift plus a thermal spread, so the subtraction matters.
        p.vx = 24'sd2000 + $signed(24'($urandom_range(0, 1200))) - 24'sd600;
        p.vy = -24'sd900 + $signed(24'($urandom_range(0, 1200))) - 24'sd600;
        p.vz = $signed(24'($urandom_range(0, 1200))) - 24'sd600;
      end
    endcase
    p.w = ($urandom_range(0, 7) == 0) ? 24'($urandom) : 24'($urandom_range(0, 300));
    p.has_fixed = 1'b0;
    p.fixed_temp = 0;
    return p;
  endfunction

  particle_row_t directed_rows[$];

  function automatic particle_row_t row(input logic f, input logic [1:0] s,
                                        input int x, input int y, input int z,
                                        input int w, input bit fx, input int ft);
    particle_row_t p;
    p.func = f; p.sp = s; p.vx = 24'(x); p.vy = 24'(y); p.vz = 24'(z); p.w = 24'(w);
    p.has_fixed = fx; p.fixed_temp = ft;
    return p;
  endfunction

  initial begin
    particle_row_t p;
    in_ch.valid = 1'b0;
    in_ch.func = stm_pkg::FUNC_ACC;
    in_ch.type_index = '0;
    in_ch.vel_x = '0;
    in_ch.vel_y = '0;
    in_ch.vel_z = '0;
    in_ch.weight = '0;
    drift_on = 1'b1;
    for (int i = 0; i < 4; i++) mass_scale[i] = 0;
    for (int i = 0; i < NSP; i++) begin
      sq_acc[i] = 0; vx_acc[i] = 0; vy_acc[i] = 0; vz_acc[i] = 0; w_acc[i] = 0;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Right after reset every species is empty and every mass scale is zero.
    directed_rows.push_back(row(stm_pkg::FUNC_REPORT, 0, 0, 0, 0, 0, 1, 0));
    directed_rows.push_back(row(stm_pkg::FUNC_ACC, 1, 256, 0, 0, 5, 0, 0));
    directed_rows.push_back(row(stm_pkg::FUNC_REPORT, 0, 0, 0, 0, 0, 1, 0));
    foreach (directed_rows[i]) send_particle(directed_rows[i]);
    drain_reports();
    directed_rows.delete();

    write_reg(stm_pkg::CFG_MS0, 32'hFFFF_FFFF);
    write_reg(stm_pkg::CFG_MS1, 32'h0001_0000);
    write_reg(stm_pkg::CFG_MS2, 32'h0000_0001);
    write_reg(stm_pkg::CFG_MS3, 32'h0003_8000);
    // Extreme velocities and weights; sums saturate.
    directed_rows.push_back(row(stm_pkg::FUNC_ACC, 0, -8388608, -8388608, -8388608,
                                16777215, 0, 0));
    directed_rows.push_back(row(stm_pkg::FUNC_ACC, 0, -8388608, -8388608, -8388608,
                                16777215, 0, 0));
    directed_rows.push_back(row(stm_pkg::FUNC_ACC, 1, 8388607, 8388607, 8388607,
                                16777215, 0, 0));
    directed_rows.push_back(row(stm_pkg::FUNC_ACC, 1, 8388607, 8388607, 8388607,
                                16777215, 0, 0));
    directed_rows.push_back(row(stm_pkg::FUNC_ACC, 2, 256, 256, 256, 0, 0, 0));
    directed_rows.push_back(row(stm_pkg::FUNC_ACC, 3, 512, -256, 128, 1, 0, 0));
    directed_rows.push_back(row(stm_pkg::FUNC_ACC, 3, 512, -256, 128, 2, 0, 0));
    directed_rows.push_back(row(stm_pkg::FUNC_REPORT, 3, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(row(stm_pkg::FUNC_ACC, 2, 300, -20, 5, 10, 0, 0));
    directed_rows.push_back(row(stm_pkg::FUNC_ACC, 2, -300, 20, -5, 10, 0, 0));
    directed_rows.push_back(row(stm_pkg::FUNC_REPORT, 0, 0, 0, 0, 0, 0, 0));
    foreach (directed_rows[i]) send_particle(directed_rows[i]);
    drain_reports();

    // Drift off, then random sets with a mix of register settings.
    write_reg(stm_pkg::CFG_DRIFT, 32'd0);
    foreach (directed_rows[i]) send_particle(directed_rows[i]);
    drain_reports();

    for (int phase = 0; phase < 4; phase++) begin
      write_reg(stm_pkg::CFG_DRIFT, 32'(phase[0]));
      for (int i = 0; i < 4; i++)
        write_reg(stm_pkg::CFG_MS0 + i[2:0], (phase == 3) ? 32'h0 : $urandom);
      for (int n = 0; n < 38; n++) begin
        p = rand_particle(12);
        send_particle(p);
      end
      p = row(stm_pkg::FUNC_REPORT, 0, 0, 0, 0, 0, 0, 0);
      send_particle(p);
      drain_reports();
    end
    stim_done = 1'b1;
  end

  // Result side: random backpressure, compare against the oldest prediction.
  initial begin
    stm_tb_types::species_report_t want, got;
    int hold;
    out_ch.ready = 1'b0;
    forever begin
      hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
      if (hold > 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      got = '{out_ch.out_type, out_ch.occupied, out_ch.temperature, out_ch.last};
      if (pending_reports.size() == 0) begin
        $display("%0t: unexpected result expected none actual %p", $time, got);
        errors++;
      end else begin
        want = pending_reports.pop_front();
        if (got !== want) begin
          $display("%0t: mismatch expected %p actual %p", $time, want, got);
          errors++;
        end
      end
    end
  end

  initial begin
    wait (stim_done);
    repeat (200) @(posedge clk);
    if (errors == 0 && pending_reports.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/stm_pkg.sv
sv/stm_in_if.sv
sv/stm_out_if.sv
sv/stm_div.sv
sv/species_temperature_moments.sv
tb/stm_tb_if.sv
tb/species_temperature_moments_tb.sv
